// ----- sv/fsp_pkg.sv -----
`timescale 1ns / 1ps

package fsp_pkg;

  localparam int MAX_SEP = 8;
  localparam int MAX_LEN = 65536;

  localparam int BYTE_W     = 8;
  localparam int SEP_W      = 64;
  localparam int LEN_W      = 4;
  localparam int PLEN_W     = 17;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int WIN_DEPTH  = MAX_SEP - 1;
  localparam int WIN_SLOTS  = (WIN_DEPTH > 0) ? WIN_DEPTH : 1;
  localparam int SEP_IDX_W  = (MAX_SEP > 1) ? $clog2(MAX_SEP) : 1;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_BYTES = 1'b0,
    REG_SEP_LEN   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              shift;
    logic [BYTE_W-1:0] cur;
  } fsp_win_ctrl_t;

  typedef struct packed {
    logic [PLEN_W-1:0] prefix_len;
    logic              found;
    logic              too_long;
  } fsp_res_t;

  function automatic logic [BYTE_W-1:0] sep_byte(input logic [SEP_W-1:0] sep,
                                                 input logic [SEP_IDX_W-1:0] k);
    sep_byte = sep[BYTE_W*k +: BYTE_W];
  endfunction

endpackage

// ----- sv/fsp_if.sv -----
`timescale 1ns / 1ps

interface fsp_in_if import fsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              no_byte;
  logic              last;

  modport source (output valid, output text_byte, output no_byte, output last,
                  input ready);
  modport sink (input valid, input text_byte, input no_byte, input last,
                output ready);
endinterface

interface fsp_out_if import fsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PLEN_W-1:0] prefix_len;
  logic              found;
  logic              too_long;

  modport source (output valid, output prefix_len, output found, output too_long,
                  input ready);
  modport sink (input valid, input prefix_len, input found, input too_long,
                output ready);
endinterface

// ----- sv/first_separator_prefix_length.sv -----
`timescale 1ns / 1ps

// First separator prefix length.
// in_ch carries one text byte per transfer (no_byte marks an item without a
// byte, last closes the text). After the transfer carrying last, one result
// (prefix_len, found, too_long) is registered and presented on out_ch.
// Every separator alignment is checked at once against a chain of byte
// cells, so one item is taken per cycle while in_ch.ready is high, with no gap between texts.
// The separator is set through cfg_we / cfg_idx / cfg_wdata: index 0 holds
// the separator bytes (byte k in bits 8k+7:8k), index 1 the length 0..15 (above 8 acts as 8).
// Result path: an output register plus one skid entry. Items keep flowing
// while a result waits; in_ch.ready drops only once both result slots are
// full, i.e. a second text has ended while the first result is unread.
// Reset (synchronous, rst_n low) clears the separator to empty, the count,
// the match record and both result slots. The byte window is not cleared;
// the byte count guards every read of it.
module first_separator_prefix_length import fsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fsp_in_if.sink               in_ch,
  fsp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SEP_W-1:0]     cfg_wdata
);

  logic [SEP_W-1:0] sep_r;
  logic [LEN_W-1:0] sep_len_r;
  logic [LEN_W-1:0] n;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             seen_r, seen_nxt;
  logic             ovf_r, ovf_nxt;

  logic             in_fire;
  logic             push;
  logic             res_fire;
  logic             tail_match;
  logic [CNT_W:0]   cnt_p1;
  fsp_win_ctrl_t    win_ctrl;
  fsp_res_t         res;

  fsp_res_t         out_r, out_nxt;
  fsp_res_t         pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pend_valid_r, pend_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r     <= '0;
      sep_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_SEP_BYTES: sep_r     <= cfg_wdata;
        REG_SEP_LEN:   sep_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign n = (sep_len_r > LEN_W'(MAX_SEP)) ? LEN_W'(MAX_SEP) : sep_len_r;

  assign in_ch.ready = !pend_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push        = in_fire && !in_ch.no_byte;
  assign res_fire    = in_fire && in_ch.last;

  assign win_ctrl.shift = push;
  assign win_ctrl.cur   = in_ch.text_byte;

  fsp_window u_window (
    .clk        (clk),
    .ctrl       (win_ctrl),
    .n          (n),
    .sep        (sep_r),
    .tail_match (tail_match)
  );

  always_comb begin
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    ovf_nxt  = ovf_r;
    cnt_p1   = {1'b0, cnt_r} + (CNT_W+1)'(1);
    if (push) begin
      if (cnt_r >= CNT_W'(MAX_LEN)) begin
        ovf_nxt = 1'b1;
      end else begin
        if (!seen_r && (n != '0) && (cnt_p1 >= (CNT_W+1)'(n)) && tail_match) begin
          seen_nxt = 1'b1;
          pos_nxt  = CNT_W'(cnt_p1 - (CNT_W+1)'(n));
        end
        cnt_nxt = cnt_p1[CNT_W-1:0];
      end
    end

    if (n == '0) begin
      res.found      = 1'b1;
      res.prefix_len = '0;
    end else if (seen_nxt) begin
      res.found      = 1'b1;
      res.prefix_len = PLEN_W'(pos_nxt);
    end else begin
      res.found      = 1'b0;
      res.prefix_len = PLEN_W'(cnt_nxt);
    end
    res.too_long = ovf_nxt;

    // Text closed: per-text state starts over.
    if (res_fire) begin
      cnt_nxt  = '0;
      pos_nxt  = '0;
      seen_nxt = 1'b0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pos_r  <= '0;
      seen_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_nxt        = out_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    if (!out_valid_r || out_ch.ready) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_fire;
      end
    end else if (res_fire) begin
      pend_nxt       = res;
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.prefix_len = out_r.prefix_len;
  assign out_ch.found      = out_r.found;
  assign out_ch.too_long   = out_r.too_long;

endmodule

// ----- sv/fsp_cell.sv -----
`timescale 1ns / 1ps

module fsp_cell import fsp_pkg::*; (
  input  logic                 clk,
  input  logic                 shift,
  input  logic [BYTE_W-1:0]    din,
  input  logic [SEP_IDX_W-1:0] idx,
  input  logic [LEN_W-1:0]     n,
  input  logic [SEP_W-1:0]     sep,
  output logic [BYTE_W-1:0]    dout,
  output logic                 eq
);

  logic [BYTE_W-1:0] byte_r;
  logic [LEN_W:0]    need;
  logic [LEN_W:0]    k;

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_r <= din;
    end
  end

  // This cell holds the byte idx+1 places back; it lines up with
  // separator byte n-2-idx, or lies outside the separator entirely.
  always_comb begin
    need = (LEN_W+1)'(idx) + (LEN_W+1)'(2);
    k    = {1'b0, n} - need;
    if (need > {1'b0, n}) begin
      eq = 1'b1;
    end else begin
      eq = (byte_r == sep_byte(sep, k[SEP_IDX_W-1:0]));
    end
  end

  assign dout = byte_r;

endmodule

// ----- sv/fsp_window.sv -----
`timescale 1ns / 1ps

module fsp_window import fsp_pkg::*; (
  input  logic             clk,
  input  fsp_win_ctrl_t    ctrl,
  input  logic [LEN_W-1:0] n,
  input  logic [SEP_W-1:0] sep,
  output logic             tail_match
);

  logic [WIN_SLOTS-1:0] eq;
  logic [BYTE_W-1:0]    chain [WIN_SLOTS];
  logic [LEN_W-1:0]     n_m1;
  logic                 cur_eq;

  generate
    if (WIN_DEPTH == 0) begin : g_no_win
      assign eq       = '1;
      assign chain[0] = ctrl.cur;
    end else begin : g_win
      for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
        logic [BYTE_W-1:0] din;
        if (j == 0) begin : g_head
          assign din = ctrl.cur;
        end else begin : g_body
          assign din = chain[j-1];
        end
        fsp_cell u_cell (
          .clk   (clk),
          .shift (ctrl.shift),
          .din   (din),
          .idx   (SEP_IDX_W'(j)),
          .n     (n),
          .sep   (sep),
          .dout  (chain[j]),
          .eq    (eq[j])
        );
      end
    end
  endgenerate

  // Newest byte lines up with the separator's final byte.
  always_comb begin
    n_m1   = n - LEN_W'(1);
    cur_eq = (ctrl.cur == sep_byte(sep, n_m1[SEP_IDX_W-1:0]));
  end

  assign tail_match = cur_eq && (&eq);

endmodule

// ----- dv/first_separator_prefix_length_tb.sv -----
`timescale 1ns / 1ps

module first_separator_prefix_length_tb;
  import fsp_pkg::*;

  localparam int          RAND_ITEMS  = 1300;
  localparam int          SETTLE      = 4;
  localparam int          HOLD_CYCLES = 400;
  localparam int unsigned LIMIT       = 5_000_000;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

  typedef struct {
    row_kind_t         kind;
    cfg_reg_t          reg_idx;
    logic [SEP_W-1:0]  value;
    logic [BYTE_W-1:0] b;
    bit                nb;
    bit                lst;
    int                reps;
    bit                typed;
    fsp_res_t          want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SEP_W-1:0]     cfg_wdata;

  fsp_in_if  in_ch();
  fsp_out_if out_ch();

  first_separator_prefix_length i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // separator copy and per-text tracking state
  logic [SEP_W-1:0]  sep_pat = '0;
  logic [LEN_W-1:0]  sep_n   = '0;
  logic [BYTE_W-1:0] recent[WIN_SLOTS];
  int unsigned       txt_cnt = 0;
  bit                hit_seen = 0;
  int unsigned       hit_pos = 0;
  bit                txt_ovf = 0;

  fsp_res_t  prefix_res_q[$];
  stim_row_t stim_rows[$];
  int        fails = 0;
  int        rand_items = 0;
  int        burst_left = 0;
  bit        hold_req = 0;

  function automatic int unsigned active_n();
    return (sep_n > MAX_SEP) ? MAX_SEP : sep_n;
  endfunction

  function automatic bit prefix_step(input logic [BYTE_W-1:0] b, input bit nb,
                                     input bit lst, output fsp_res_t res);
    int unsigned n;
    int unsigned k;
    int unsigned back;
    logic [BYTE_W-1:0] cmp;
    bit hit;
    n = active_n();
    res = '0;
    if (!nb) begin
      if (txt_cnt >= MAX_LEN) begin
        txt_ovf = 1'b1;
      end else begin
        if (!hit_seen && n > 0 && txt_cnt + 1 >= n) begin
          hit = 1'b1;
          for (k = 0; k < n; k++) begin
            back = n - 1 - k;
            cmp = (back == 0) ? b : recent[back-1];
            if (cmp != sep_pat[8*k +: 8]) hit = 1'b0;
          end
          if (hit) begin
            hit_seen = 1'b1;
            hit_pos = txt_cnt + 1 - n;
          end
        end
        txt_cnt++;
      end
      for (k = WIN_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
    end
    if (!lst) return 1'b0;
    if (n == 0) begin
      res.found = 1'b1;
    end else if (hit_seen) begin
      res.found = 1'b1;
      res.prefix_len = PLEN_W'(hit_pos);
    end else begin
      res.prefix_len = PLEN_W'(txt_cnt);
    end
    res.too_long = txt_ovf;
    txt_cnt = 0;
    hit_seen = 1'b0;
    hit_pos = 0;
    txt_ovf = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [SEP_W-1:0] val);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = val;
    r.reps = 0;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [BYTE_W-1:0] b, bit nb, bit lst, int reps);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.b = b;
    r.nb = nb;
    r.lst = lst;
    r.reps = reps;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // closing item of a text whose result is known by inspection
  function automatic stim_row_t end_row(logic [BYTE_W-1:0] b, bit nb, int unsigned plen,
                                        bit found, bit too_long);
    stim_row_t r;
    r = item_row(b, nb, 1'b1, 1);
    r.typed = 1'b1;
    r.want.prefix_len = PLEN_W'(plen);
    r.want.found = found;
    r.want.too_long = too_long;
    return r;
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] b, input bit nb, input bit lst,
                           input bit typed, input fsp_res_t want);
    int gap;
    fsp_res_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.no_byte   <= nb;
    in_ch.last      <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (prefix_step(b, nb, lst, res)) prefix_res_q.push_back(typed ? want : res);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (prefix_res_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [SEP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEP_BYTES) sep_pat = val;
    else sep_n = val[LEN_W-1:0];
    @(posedge clk);
  endtask

  task automatic random_setup();
    logic [SEP_W-1:0] pat;
    int pick;
    int len_pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) pat = '0;
    else if (pick == 1) pat = '1;
    else if (pick < 6) pat = ({$urandom(), $urandom()} & {8{8'h03}}) | {8{8'h60}};
    else pat = {$urandom(), $urandom()};
    len_pick = $urandom_range(0, 9);
    write_reg(REG_SEP_BYTES, pat);
    if (len_pick == 0) write_reg(REG_SEP_LEN, SEP_W'(0));
    else if (len_pick < 3) write_reg(REG_SEP_LEN, SEP_W'(MAX_SEP));
    else write_reg(REG_SEP_LEN, SEP_W'($urandom_range(1, MAX_SEP - 1)));
  endtask

  // Text built mostly from separator bytes, sometimes with the whole
  // separator or its head planted, plus stray no-byte items.
  task automatic random_text();
    logic [BYTE_W-1:0] txt[$];
    int len;
    int r;
    int k;
    int at;
    int n;
    int sel;
    bit tail_nb;
    r = $urandom_range(0, 19);
    len = (r < 13) ? $urandom_range(0, 12) :
          (r < 19) ? $urandom_range(13, 60) : $urandom_range(61, 300);
    for (k = 0; k < len; k++) begin
      sel = $urandom_range(0, MAX_SEP - 1);
      if ($urandom_range(0, 3) == 0) txt.push_back(BYTE_W'($urandom_range(0, 255)));
      else txt.push_back(sep_pat[8*sel +: 8]);
    end
    n = active_n();
    if (n > 0 && len >= n && $urandom_range(0, 4) < 2) begin
      at = $urandom_range(0, len - n);
      for (k = 0; k < n; k++) txt[at+k] = sep_pat[8*k +: 8];
    end
    if (n > 1 && len >= n - 1 && $urandom_range(0, 4) == 0) begin
      at = len - (n - 1);
      for (k = 0; k < n - 1; k++) txt[at+k] = sep_pat[8*k +: 8];
    end
    tail_nb = (len == 0) || ($urandom_range(0, 4) == 0);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
      send_item(txt[k], 1'b0, !tail_nb && k == len - 1, 1'b0, '0);
      rand_items++;
    end
    if (tail_nb) begin
      send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, '0);
      rand_items++;
    end
  endtask

  // result sink: own stall pattern, plus one long hold-off on request
  initial begin
    sink_mode_t mode;
    int mode_left;
    int hold_cnt;
    int unsigned tick;
    out_ch.ready <= 1'b0;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_cnt = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ch.ready <= (tick % 4 == 0);
          default:     out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    fsp_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (prefix_res_q.size() == 0) begin
        $error("result with nothing pending: prefix_len %0d found %0b too_long %0b",
               out_ch.prefix_len, out_ch.found, out_ch.too_long);
        fails++;
      end else begin
        want = prefix_res_q.pop_front();
        if (out_ch.prefix_len !== want.prefix_len) begin
          $error("prefix_len: expected %0d, actual %0d", want.prefix_len, out_ch.prefix_len);
          fails++;
        end
        if (out_ch.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, out_ch.found);
          fails++;
        end
        if (out_ch.too_long !== want.too_long) begin
          $error("too_long: expected %0b, actual %0b", want.too_long, out_ch.too_long);
          fails++;
        end
      end
    end
  end

  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_SEP_BYTES;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.no_byte   <= 1'b0;
    in_ch.last      <= 1'b0;

    // empty separator out of reset, for an empty and a one-byte text
    stim_rows.push_back(end_row(8'h00, 1'b1, 0, 1'b1, 1'b0));
    stim_rows.push_back(end_row(8'hFF, 1'b0, 0, 1'b1, 1'b0));
    // eight-byte all-ones separator
    stim_rows.push_back(cfg_row(REG_SEP_BYTES, '1));
    stim_rows.push_back(cfg_row(REG_SEP_LEN, SEP_W'(MAX_SEP)));
    stim_rows.push_back(end_row(8'h00, 1'b1, 0, 1'b0, 1'b0));
    stim_rows.push_back(item_row(8'hFF, 1'b0, 1'b0, 7));
    stim_rows.push_back(end_row(8'hFF, 1'b0, 0, 1'b1, 1'b0));
    // stray no-byte item inside the run must not disturb the window
    stim_rows.push_back(item_row(8'h00, 1'b0, 1'b0, 1));
    stim_rows.push_back(item_row(8'hFF, 1'b0, 1'b0, 7));
    stim_rows.push_back(item_row(8'h00, 1'b1, 1'b0, 1));
    stim_rows.push_back(end_row(8'hFF, 1'b0, 1, 1'b1, 1'b0));
    // length beyond eight acts as eight
    stim_rows.push_back(cfg_row(REG_SEP_LEN, SEP_W'(12)));
    stim_rows.push_back(item_row(8'hFF, 1'b0, 1'b0, 7));
    stim_rows.push_back(end_row(8'hFF, 1'b0, 0, 1'b1, 1'b0));
    // single zero byte separator
    stim_rows.push_back(cfg_row(REG_SEP_BYTES, '0));
    stim_rows.push_back(cfg_row(REG_SEP_LEN, SEP_W'(1)));
    stim_rows.push_back(item_row(8'h01, 1'b0, 1'b0, 1));
    stim_rows.push_back(item_row(8'h02, 1'b0, 1'b0, 1));
    stim_rows.push_back(end_row(8'h00, 1'b0, 2, 1'b1, 1'b0));
    stim_rows.push_back(end_row(8'h05, 1'b0, 1, 1'b0, 1'b0));
    // "ABC": head at text end, then no carry of old bytes into a new text
    stim_rows.push_back(cfg_row(REG_SEP_BYTES, SEP_W'(64'h0000_0000_0043_4241)));
    stim_rows.push_back(cfg_row(REG_SEP_LEN, SEP_W'(3)));
    stim_rows.push_back(item_row(8'h41, 1'b0, 1'b0, 1));
    stim_rows.push_back(end_row(8'h42, 1'b0, 2, 1'b0, 1'b0));
    stim_rows.push_back(end_row(8'h43, 1'b0, 1, 1'b0, 1'b0));
    stim_rows.push_back(item_row(8'h5A, 1'b0, 1'b0, 2));
    stim_rows.push_back(item_row(8'h41, 1'b0, 1'b0, 2));
    stim_rows.push_back(item_row(8'h42, 1'b0, 1'b0, 1));
    stim_rows.push_back(item_row(8'h43, 1'b0, 1'b1, 1));
    // match only after saturation is ignored
    stim_rows.push_back(item_row(8'h00, 1'b0, 1'b0, MAX_LEN));
    stim_rows.push_back(item_row(8'h41, 1'b0, 1'b0, 1));
    stim_rows.push_back(item_row(8'h42, 1'b0, 1'b0, 1));
    stim_rows.push_back(end_row(8'h43, 1'b0, MAX_LEN, 1'b0, 1'b1));
    // match ending on the last counted byte, then one byte past the limit
    stim_rows.push_back(item_row(8'h00, 1'b0, 1'b0, MAX_LEN - 3));
    stim_rows.push_back(item_row(8'h41, 1'b0, 1'b0, 1));
    stim_rows.push_back(item_row(8'h42, 1'b0, 1'b0, 1));
    stim_rows.push_back(item_row(8'h43, 1'b0, 1'b0, 1));
    stim_rows.push_back(end_row(8'h5A, 1'b0, MAX_LEN - 3, 1'b1, 1'b1));
    // exactly at the limit, no match
    stim_rows.push_back(item_row(8'h00, 1'b0, 1'b0, MAX_LEN - 1));
    stim_rows.push_back(end_row(8'h00, 1'b0, MAX_LEN, 1'b0, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].value);
      end else begin
        repeat (stim_rows[i].reps)
          send_item(stim_rows[i].b, stim_rows[i].nb, stim_rows[i].lst,
                    stim_rows[i].typed, stim_rows[i].want);
      end
    end

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      drain();
      random_setup();
      // first phase: sink holds off while texts keep coming in
      if (phase == 0) hold_req = 1'b1;
      repeat ($urandom_range(8, 24)) random_text();
      phase++;
    end

    drain();
    if (fails == 0 && prefix_res_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
